// ----- rtl/mthw_pkg.sv -----
package mthw_pkg;

   localparam int unsigned FUNC_W = 2;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned CNT_W  = 5;
   localparam int unsigned HB_W   = 16;
   localparam int unsigned EPS_W  = 10;
   localparam int unsigned TO_W   = 32;
   localparam int unsigned REQ_ID_W = 4;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_HEARTBEAT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON   = 1'd1;

   localparam logic [HB_W-1:0]  HEARTBEAT_RESET = 16'd1000;
   localparam logic [EPS_W-1:0] EPSILON_RESET   = 10'd1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START = 2'd0,
      FUNC_TOUCH = 2'd1,
      FUNC_STOP  = 2'd2,
      FUNC_CHECK = 2'd3
   } func_type;

   localparam logic [KIND_W-1:0] KIND_ACK     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HANG    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NO_TASK = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DUP     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd5;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_REARM,
      OP_CHAIN_STEP,
      OP_SCAN_INIT,
      OP_SCAN_STEP,
      OP_VISIT,
      OP_FREE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   send;
      logic [KIND_W-1:0] kind;
      logic   last;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic id_ok;
      logic id_valid;
      logic chain_go;
      logic scan_end;
      logic found;
      logic visit_report;
      logic visit_hang;
   } sts_type;

endpackage

// ----- rtl/multi_task_hang_watchdog.sv -----
// Start/touch/stop: decode, then the parent walk, one step a cycle.
// Check sweep: repeated passes over all slots, one slot compared a cycle
// in the deadline-order selection scan; one item in flight at a time.
// Throughput: next item taken once busy falls; each result shows for one cycle.
// Reset: synchronous active high; clears the table valid/hung/parent/remove bits,
// the hung count and the registers to heartbeat 1000 and epsilon 1.
module multi_task_hang_watchdog #(
   parameter int unsigned NUM_TASKS = 16,
   parameter int unsigned TIME_BITS = 48
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic csr_we,
   input  logic [mthw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mthw_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [1:0] req_func,
   input  logic [3:0] req_task_id,
   input  logic [3:0] req_parent_id,
   input  logic req_has_parent,
   input  logic [31:0] req_timeout_ms,
   input  logic [47:0] req_now_ms,
   output logic rsp_valid,
   output logic [2:0] rsp_result_kind,
   output logic [3:0] rsp_report_task,
   output logic [4:0] rsp_other_hung,
   output logic [47:0] rsp_hang_length_ms,
   output logic [4:0] rsp_hung_total,
   output logic rsp_last
);
   import mthw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mthw_ctrl u_ctrl (
      .clock, .reset, .req_start(start), .req_busy(busy), .sts, .cmd
   );

   mthw_datapath #(.NUM_TASKS(NUM_TASKS), .TIME_BITS(TIME_BITS)) u_dp (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_func, .req_task_id, .req_parent_id, .req_has_parent,
      .req_timeout_ms, .req_now_ms, .cmd, .sts,
      .rsp_valid, .rsp_result_kind, .rsp_report_task, .rsp_other_hung,
      .rsp_hang_length_ms, .rsp_hung_total, .rsp_last
   );

endmodule

// ----- rtl/mthw_datapath.sv -----
module mthw_datapath #(
   parameter int unsigned NUM_TASKS = 16,
   parameter int unsigned TIME_BITS = 48
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [mthw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mthw_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [1:0] req_func,
   input  logic [3:0] req_task_id,
   input  logic [3:0] req_parent_id,
   input  logic req_has_parent,
   input  logic [31:0] req_timeout_ms,
   input  logic [47:0] req_now_ms,
   input  mthw_pkg::cmd_type cmd,
   output mthw_pkg::sts_type sts,
   output logic rsp_valid,
   output logic [2:0] rsp_result_kind,
   output logic [3:0] rsp_report_task,
   output logic [4:0] rsp_other_hung,
   output logic [47:0] rsp_hang_length_ms,
   output logic [4:0] rsp_hung_total,
   output logic rsp_last
);
   import mthw_pkg::*;

   localparam int unsigned SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int unsigned CW = $clog2(NUM_TASKS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

   logic [HB_W-1:0]  heartbeat_ff;
   logic [EPS_W-1:0] epsilon_ff;

   logic [NUM_TASKS-1:0] valid_ff, hung_ff, pflag_ff, remove_ff, seen_ff;
   logic [TIME_BITS-1:0] deadline_ff [NUM_TASKS];
   logic [TO_W-1:0]      thresh_ff   [NUM_TASKS];
   logic [TIME_BITS-1:0] hung_at_ff  [NUM_TASKS];
   logic [SW-1:0]        pslot_ff    [NUM_TASKS];
   logic [CNT_W-1:0]     hung_count_ff;

   func_type            func_ff;
   logic [3:0]          id_ff, pid_ff;
   logic                hp_ff;
   logic [TO_W-1:0]     to_ff;
   logic [TIME_BITS-1:0] now_ff, t_ff;
   logic [SW-1:0]       slot_ff, scan_ff, best_ff;
   logic                best_ok_ff;
   logic [CW-1:0]       steps_ff;

   logic [SW-1:0] id_s, pid_s, par_s;
   logic id_ok, pid_ok;
   logic [TIME_BITS-1:0] now_t, t_next;
   logic [TO_W-1:0] to_eff;

   assign id_ok  = ({28'd0, id_ff} < 32'(NUM_TASKS));
   assign pid_ok = ({28'd0, pid_ff} < 32'(NUM_TASKS));
   assign id_s   = SW'(id_ff);
   assign pid_s  = SW'(pid_ff);
   assign par_s  = pslot_ff[slot_ff];
   assign now_t  = TIME_BITS'(req_now_ms);
   assign t_next = t_ff + TIME_BITS'(epsilon_ff);
   assign to_eff = (to_ff < TO_W'(heartbeat_ff)) ? TO_W'({heartbeat_ff, 1'b0}) : to_ff;

   logic cand, better, hang_now;
   assign cand   = valid_ff[scan_ff] && !seen_ff[scan_ff];
   assign better = cand && (!best_ok_ff || deadline_ff[scan_ff] < deadline_ff[best_ff]);
   assign hang_now = deadline_ff[best_ff] < now_ff;

   function automatic logic req_has_parent_ok();
      return hp_ff && pid_ok && valid_ff[pid_s];
   endfunction

   always_comb begin
      sts.func         = func_ff;
      sts.id_ok        = id_ok;
      sts.id_valid     = id_ok && valid_ff[id_s];
      sts.chain_go     = (32'(steps_ff) < 32'(NUM_TASKS)) && pflag_ff[slot_ff]
                         && valid_ff[par_s];
      sts.scan_end     = (32'(scan_ff) == 32'(NUM_TASKS - 1));
      sts.found        = best_ok_ff;
      sts.visit_report = hang_now ? !hung_ff[best_ff] : hung_ff[best_ff];
      sts.visit_hang   = hang_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heartbeat_ff  <= HEARTBEAT_RESET;
         epsilon_ff    <= EPSILON_RESET;
         valid_ff      <= '0;
         hung_ff       <= '0;
         pflag_ff      <= '0;
         remove_ff     <= '0;
         hung_count_ff <= '0;
         rsp_valid     <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_HEARTBEAT) heartbeat_ff <= csr_wdata;
            if (csr_index == CSR_EPSILON)   epsilon_ff   <= csr_wdata[EPS_W-1:0];
         end
         rsp_valid <= cmd.send;
         case (cmd.op)
            OP_START: begin
               thresh_ff[id_s]   <= to_eff;
               deadline_ff[id_s] <= now_ff + TIME_BITS'(to_eff);
               hung_ff[id_s]     <= 1'b0;
               hung_at_ff[id_s]  <= '0;
               remove_ff[id_s]   <= 1'b0;
               pflag_ff[id_s]    <= req_has_parent_ok();
               pslot_ff[id_s]    <= req_has_parent_ok() ? pid_s : '0;
               valid_ff[id_s]    <= 1'b1;
            end
            OP_REARM: begin
               deadline_ff[id_s] <= now_ff + TIME_BITS'(thresh_ff[id_s]);
               if (func_ff == FUNC_STOP) remove_ff[id_s] <= 1'b1;
            end
            OP_CHAIN_STEP:
               deadline_ff[par_s] <= t_next + TIME_BITS'(thresh_ff[par_s]);
            OP_VISIT: begin
               if (hang_now && !hung_ff[best_ff]) begin
                  hung_ff[best_ff]    <= 1'b1;
                  hung_at_ff[best_ff] <= deadline_ff[best_ff];
                  if (hung_count_ff < CNT_MAX) hung_count_ff <= hung_count_ff + 1'b1;
               end else if (!hang_now && hung_ff[best_ff]) begin
                  hung_ff[best_ff] <= 1'b0;
                  if (hung_count_ff != '0) hung_count_ff <= hung_count_ff - 1'b1;
               end
            end
            OP_FREE: begin
               valid_ff  <= valid_ff & ~remove_ff;
               hung_ff   <= hung_ff & ~remove_ff;
               pflag_ff  <= pflag_ff & ~remove_ff;
               remove_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            func_ff <= func_type'(req_func);
            id_ff   <= req_task_id;
            pid_ff  <= req_parent_id;
            hp_ff   <= req_has_parent;
            to_ff   <= req_timeout_ms;
            now_ff  <= now_t;
            t_ff    <= now_t;
            slot_ff <= SW'(req_task_id);
            steps_ff <= '0;
            seen_ff <= '0;
         end
         OP_CHAIN_STEP: begin
            t_ff     <= t_next;
            slot_ff  <= par_s;
            steps_ff <= steps_ff + 1'b1;
         end
         OP_SCAN_INIT: begin
            scan_ff    <= '0;
            best_ok_ff <= 1'b0;
         end
         OP_SCAN_STEP: begin
            if (better) begin
               best_ff    <= scan_ff;
               best_ok_ff <= 1'b1;
            end
            scan_ff <= scan_ff + 1'b1;
         end
         OP_VISIT: seen_ff[best_ff] <= 1'b1;
         default: ;
      endcase
      if (cmd.send) begin
         rsp_result_kind    <= cmd.kind;
         rsp_last           <= cmd.last;
         rsp_report_task    <= (cmd.kind == KIND_HANG || cmd.kind == KIND_RESUME)
                               ? 4'(best_ff)
                               : ((cmd.kind == KIND_DONE) ? 4'd0 : id_ff);
         rsp_other_hung     <= (cmd.kind == KIND_HANG) ? hung_count_ff : '0;
         rsp_hang_length_ms <= (cmd.kind == KIND_RESUME)
            ? 48'(deadline_ff[best_ff] - (hung_at_ff[best_ff]
                  + TIME_BITS'(thresh_ff[best_ff]))) : '0;
         rsp_hung_total     <= (cmd.kind == KIND_DONE) ? hung_count_ff : '0;
      end
   end

   hung_count_bound: assert property (@(posedge clock) disable iff (reset)
      hung_count_ff <= CNT_MAX) else $error("hung count out of range");
   seen_only_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_VISIT |-> best_ok_ff && valid_ff[best_ff])
      else $error("visit of invalid slot");
   free_clears_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FREE |=> remove_ff == '0) else $error("marks left after free");

endmodule

// ----- rtl/mthw_ctrl.sv -----
module mthw_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_start,
   output logic req_busy,
   input  mthw_pkg::sts_type sts,
   output mthw_pkg::cmd_type cmd
);
   import mthw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_CHAIN, S_SCAN, S_VISIT, S_FREE, S_DONE
   } state_type;

   state_type state_ff;

   assign req_busy = (state_ff != S_IDLE);

   always_comb begin
      cmd = '{op: OP_NONE, send: 1'b0, kind: KIND_ACK, last: 1'b0};
      case (state_ff)
         S_IDLE: if (req_start) cmd.op = OP_LOAD;
         S_DECODE: begin
            if (sts.func == FUNC_CHECK) cmd.op = OP_SCAN_INIT;
            else if (!sts.id_ok) begin
               cmd.send = 1'b1; cmd.kind = KIND_NO_TASK; cmd.last = 1'b1;
            end else if (sts.func == FUNC_START) begin
               if (sts.id_valid) begin
                  cmd.send = 1'b1; cmd.kind = KIND_DUP; cmd.last = 1'b1;
               end else cmd.op = OP_START;
            end else if (!sts.id_valid) begin
               cmd.send = 1'b1; cmd.kind = KIND_NO_TASK; cmd.last = 1'b1;
            end else cmd.op = OP_REARM;
         end
         S_CHAIN: begin
            if (sts.chain_go) cmd.op = OP_CHAIN_STEP;
            else begin
               cmd.send = 1'b1; cmd.kind = KIND_ACK; cmd.last = 1'b1;
            end
         end
         S_SCAN: cmd.op = OP_SCAN_STEP;
         S_VISIT: begin
            if (sts.found) begin
               cmd.op = OP_VISIT;
               cmd.send = sts.visit_report;
               cmd.kind = sts.visit_hang ? KIND_HANG : KIND_RESUME;
            end else cmd.op = OP_FREE;
         end
         S_FREE: cmd.op = OP_SCAN_INIT;
         S_DONE: begin
            cmd.send = 1'b1; cmd.kind = KIND_DONE; cmd.last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (req_start) state_ff <= S_DECODE;
            S_DECODE: begin
               if (sts.func == FUNC_CHECK) state_ff <= S_SCAN;
               else if (cmd.send) state_ff <= S_IDLE;
               else state_ff <= S_CHAIN;
            end
            S_CHAIN: if (!sts.chain_go) state_ff <= S_IDLE;
            S_SCAN: if (sts.scan_end) state_ff <= S_VISIT;
            S_VISIT: state_ff <= sts.found ? S_FREE : S_DONE;
            S_FREE: state_ff <= S_SCAN;
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> state_ff == S_IDLE) else $error("done did not finish");
   last_ends_item: assert property (@(posedge clock) disable iff (reset)
      cmd.send && cmd.last |=> state_ff == S_IDLE) else $error("last without end");
   load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOAD |-> state_ff == S_IDLE) else $error("load while busy");

endmodule

// ----- bench/multi_task_hang_watchdog_test.sv -----
`timescale 1ns / 100ps

module multi_task_hang_watchdog_test;
   import mthw_pkg::*;

   localparam int SLOTS = 16;
   localparam logic [47:0] TMASK = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  task_slot;
      logic [4:0]  other;
      logic [47:0] hang_len;
      logic [4:0]  total;
      logic        last;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic [1:0] req_func = '0;
   logic [3:0] req_task_id = '0;
   logic [3:0] req_parent_id = '0;
   logic req_has_parent = 1'b0;
   logic [31:0] req_timeout_ms = '0;
   logic [47:0] req_now_ms = '0;
   logic rsp_valid;
   logic [2:0] rsp_result_kind;
   logic [3:0] rsp_report_task;
   logic [4:0] rsp_other_hung;
   logic [47:0] rsp_hang_length_ms;
   logic [4:0] rsp_hung_total;
   logic rsp_last;

   multi_task_hang_watchdog DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_func(req_func), .req_task_id(req_task_id), .req_parent_id(req_parent_id),
      .req_has_parent(req_has_parent), .req_timeout_ms(req_timeout_ms),
      .req_now_ms(req_now_ms), .rsp_valid(rsp_valid),
      .rsp_result_kind(rsp_result_kind), .rsp_report_task(rsp_report_task),
      .rsp_other_hung(rsp_other_hung), .rsp_hang_length_ms(rsp_hang_length_ms),
      .rsp_hung_total(rsp_hung_total), .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog shadow state
   logic [15:0] hb;
   logic [9:0]  eps;
   logic        live [SLOTS];
   logic [47:0] due [SLOTS];
   logic [31:0] limit [SLOTS];
   logic        hung [SLOTS];
   logic [47:0] hung_since [SLOTS];
   logic [3:0]  parent [SLOTS];
   logic        has_par [SLOTS];
   logic        doomed [SLOTS];
   logic [4:0]  hung_cnt;

   report_type pending_reports[$];
   int errors = 0;
   int items_sent = 0;
   int reports_seen = 0;
   int hang_reports = 0;
   int resume_reports = 0;
   int idle_pct = 0;

   task automatic report_mismatch(input string what, input report_type got,
                                  input report_type exp);
      errors++;
      $display("ERROR %0t: %s got %h expected %h", $time, what, got, exp);
   endtask

   function automatic report_type mk(input logic [2:0] k, input logic [3:0] t,
                                     input logic [4:0] o, input logic [47:0] l,
                                     input logic [4:0] tot, input logic la);
      report_type r;
      r.kind = k; r.task_slot = t; r.other = o; r.hang_len = l; r.total = tot; r.last = la;
      return r;
   endfunction

   function automatic void queue_report(input report_type r);
      pending_reports.insert(pending_reports.size(), r);
   endfunction

   function automatic void walk_parents(input int slot, input logic [47:0] t);
      int s;
      int p;
      s = slot;
      for (int step = 0; step < SLOTS; step++) begin
         if (!has_par[s]) break;
         p = parent[s];
         if (!live[p]) break;
         t = (t + 48'(eps)) & TMASK;
         due[p] = t + 48'(limit[p]);
         s = p;
      end
   endfunction

   function automatic void predict_watchdog(input logic [1:0] fn, input logic [3:0] id,
                                            input logic [3:0] pid, input logic hp,
                                            input logic [31:0] to, input logic [47:0] now);
      logic seen [SLOTS];
      int best;
      logic [31:0] eff;
      if (fn == FUNC_CHECK) begin
         foreach (seen[i]) seen[i] = 1'b0;
         for (int n = 0; n < SLOTS; n++) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
               if (live[i] && !seen[i] && (best < 0 || due[i] < due[best])) best = i;
            if (best < 0) break;
            seen[best] = 1'b1;
            if (due[best] < now) begin
               if (!hung[best]) begin
                  queue_report(mk(KIND_HANG, 4'(best), hung_cnt, '0, '0, 1'b0));
                  hung[best] = 1'b1;
                  hung_since[best] = due[best];
                  if (hung_cnt < 31) hung_cnt++;
               end
            end else if (hung[best]) begin
               queue_report(mk(KIND_RESUME, 4'(best), '0,
                  due[best] - (hung_since[best] + 48'(limit[best])), '0, 1'b0));
               hung[best] = 1'b0;
               if (hung_cnt > 0) hung_cnt--;
            end
         end
         for (int i = 0; i < SLOTS; i++)
            if (doomed[i]) begin
               live[i] = 0; hung[i] = 0; has_par[i] = 0; doomed[i] = 0;
            end
         queue_report(mk(KIND_DONE, '0, '0, '0, hung_cnt, 1'b1));
      end else if (fn == FUNC_START) begin
         if (live[id]) begin
            queue_report(mk(KIND_DUP, id, '0, '0, '0, 1'b1));
         end else begin
            eff = (to < 32'(hb)) ? 32'(hb) * 32'd2 : to;
            limit[id] = eff;
            due[id] = now + 48'(eff);
            hung[id] = 0;
            hung_since[id] = 0;
            doomed[id] = 0;
            has_par[id] = hp && live[pid];
            parent[id] = has_par[id] ? pid : 4'd0;
            live[id] = 1;
            walk_parents(int'(id), now);
            queue_report(mk(KIND_ACK, id, '0, '0, '0, 1'b1));
         end
      end else if (!live[id]) begin
         queue_report(mk(KIND_NO_TASK, id, '0, '0, '0, 1'b1));
      end else begin
         due[id] = now + 48'(limit[id]);
         walk_parents(int'(id), now);
         if (fn == FUNC_STOP) doomed[id] = 1;
         queue_report(mk(KIND_ACK, id, '0, '0, '0, 1'b1));
      end
   endfunction

   always @(posedge clock) begin
      report_type got;
      report_type exp;
      if (!reset && rsp_valid) begin
         got = mk(rsp_result_kind, rsp_report_task, rsp_other_hung, rsp_hang_length_ms,
                  rsp_hung_total, rsp_last);
         reports_seen++;
         if (got.kind == KIND_HANG) hang_reports++;
         if (got.kind == KIND_RESUME) resume_reports++;
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected result", got, got);
         end else begin
            exp = pending_reports.pop_front();
            if (got.kind !== exp.kind) report_mismatch("result_kind", got, exp);
            if (got.task_slot !== exp.task_slot) report_mismatch("report_task", got, exp);
            if (got.other !== exp.other) report_mismatch("other_hung", got, exp);
            if (got.hang_len !== exp.hang_len) report_mismatch("hang_length_ms", got, exp);
            if (got.total !== exp.total) report_mismatch("hung_total", got, exp);
            if (got.last !== exp.last) report_mismatch("last", got, exp);
         end
      end
   end

   task automatic send_item(input logic [1:0] fn, input logic [3:0] id, input logic [3:0] pid,
                            input logic hp, input logic [31:0] to, input logic [47:0] now);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      start <= 1'b1;
      req_func <= fn; req_task_id <= id; req_parent_id <= pid;
      req_has_parent <= hp; req_timeout_ms <= to; req_now_ms <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_watchdog(fn, id, pid, hp, to, now);
      items_sent++;
      start <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HEARTBEAT) hb = val; else eps = val[9:0];
   endtask

   task automatic test_directed;
      send_item(FUNC_TOUCH, 4'd3, '0, 1'b0, '0, 48'd0);
      send_item(FUNC_STOP, 4'd15, '0, 1'b0, '0, 48'd5);
      send_item(FUNC_CHECK, '0, '0, 1'b0, '0, 48'd0);
      send_item(FUNC_START, 4'd0, 4'd9, 1'b1, 32'd0, 48'd100);
      send_item(FUNC_START, 4'd1, 4'd0, 1'b1, 32'hFFFF_FFFF, 48'd200);
      send_item(FUNC_START, 4'd2, 4'd1, 1'b1, 32'd5000, TMASK - 48'd10);
      send_item(FUNC_START, 4'd15, 4'd15, 1'b1, 32'd2000, 48'd300);
      send_item(FUNC_START, 4'd1, 4'd0, 1'b0, 32'd10, 48'd0);
      send_item(FUNC_TOUCH, 4'd2, '0, 1'b0, '0, 48'd1000);
      send_item(FUNC_CHECK, '0, '0, 1'b0, '0, 48'd5000);
      send_item(FUNC_TOUCH, 4'd0, '0, 1'b0, '0, 48'd6000);
      send_item(FUNC_CHECK, '0, '0, 1'b0, '0, 48'd6001);
      send_item(FUNC_STOP, 4'd0, '0, 1'b0, '0, 48'd7000);
      send_item(FUNC_START, 4'd0, '0, 1'b0, 32'd1, 48'd7000);
      send_item(FUNC_TOUCH, 4'd1, '0, 1'b0, '0, 48'd7100);
      send_item(FUNC_CHECK, '0, '0, 1'b0, '0, TMASK);
      send_item(FUNC_CHECK, '0, '0, 1'b0, '0, 48'd0);
      drain();
   endtask

   task automatic test_config_extremes;
      write_csr(CSR_HEARTBEAT, 16'd0);
      write_csr(CSR_EPSILON, 16'd1023);
      send_item(FUNC_START, 4'd5, '0, 1'b0, 32'd0, 48'd50);
      send_item(FUNC_START, 4'd6, 4'd5, 1'b1, 32'd3, 48'd60);
      send_item(FUNC_STOP, 4'd6, '0, 1'b0, '0, 48'd70);
      send_item(FUNC_CHECK, '0, '0, 1'b0, '0, 48'd100);
      drain();
      write_csr(CSR_HEARTBEAT, 16'hFFFF);
      write_csr(CSR_EPSILON, 16'd0);
      send_item(FUNC_START, 4'd6, 4'd5, 1'b1, 32'd100, 48'd80);
      send_item(FUNC_CHECK, '0, '0, 1'b0, '0, 48'd200000);
      drain();
   endtask

   task automatic test_random_phase(input int count, input int pct);
      logic [47:0] clk_ms;
      int r;
      idle_pct = pct;
      clk_ms = 48'($urandom_range(1000)) | (($urandom_range(1) == 1) ? 48'hFFFF_FFF0_0000 : '0);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         clk_ms = clk_ms + 48'($urandom_range(400));
         if (r < 5)
            send_item(2'($urandom_range(3)), 4'($urandom), 4'($urandom), 1'($urandom),
                      $urandom, 48'({$urandom, $urandom}));
         else if (r < 30)
            send_item(FUNC_START, 4'($urandom), 4'($urandom), $urandom_range(3) != 0,
                      ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3000)),
                      clk_ms);
         else if (r < 55)
            send_item(FUNC_TOUCH, 4'($urandom), 4'($urandom), 1'($urandom), $urandom,
                      clk_ms);
         else if (r < 72)
            send_item(FUNC_STOP, 4'($urandom), 4'($urandom), 1'($urandom), $urandom,
                      clk_ms);
         else
            send_item(FUNC_CHECK, 4'($urandom), 4'($urandom), 1'($urandom), $urandom,
                      clk_ms);
      end
      drain();
   endtask

   initial begin
      hb = 16'(HEARTBEAT_RESET);
      eps = 10'(EPSILON_RESET);
      foreach (live[i]) begin
         live[i] = 0; hung[i] = 0; has_par[i] = 0; doomed[i] = 0;
         due[i] = 0; limit[i] = 0; hung_since[i] = 0; parent[i] = 0;
      end
      hung_cnt = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      write_csr(CSR_HEARTBEAT, 16'd500);
      write_csr(CSR_EPSILON, 16'd3);
      test_random_phase(115, 12);
      write_csr(CSR_HEARTBEAT, 16'($urandom_range(2000, 1)));
      write_csr(CSR_EPSILON, 16'($urandom_range(1023)));
      test_random_phase(115, 81);
      write_csr(CSR_HEARTBEAT, 16'd1);
      write_csr(CSR_EPSILON, 16'd1);
      test_random_phase(115, 0);
      $display("Covered %0d items and %0d results (%0d hangs, %0d resumes)",
               items_sent, reports_seen, hang_reports, resume_reports);
      $display("over three idle profiles and heartbeat/epsilon settings at both extremes");
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mthw_pkg.sv
rtl/mthw_datapath.sv
rtl/mthw_ctrl.sv
rtl/multi_task_hang_watchdog.sv
bench/multi_task_hang_watchdog_test.sv
